@@ hdl/npbs_pkg.sv @@
// constants and helpers for the nearest point in box or sphere block
// register indexes, shape modes, q1.14 rounding; no dependencies
`timescale 1ns / 1ps

package npbs_pkg;

  // shape modes
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_BOX    = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
  localparam logic [2:0] REG_CENTER_X   = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_CENTER_Z   = 3'd3;
  localparam logic [2:0] REG_QUAT       = 3'd4;
  localparam logic [2:0] REG_EXTENT_X   = 3'd5;
  localparam logic [2:0] REG_EXTENT_Y   = 3'd6;
  localparam logic [2:0] REG_EXTENT_Z   = 3'd7;

  // fixed formats
  localparam int RAD_W = 31;   // extents and radius
  localparam int MAT_W = 21;   // rotation matrix entries, signed q14
  localparam int QUO_W = 32;   // sphere scale quotient bits
  localparam logic [63:0]        QUAT_RESET = 64'd16384;
  localparam logic signed [63:0] Q14_ONE    = 64'sd16384;
  localparam logic signed [63:0] Q14_HALF   = 64'sd8192;

  // round a q14-scaled sum back to integer, ties upward
  function automatic logic signed [63:0] q14_round(input logic signed [63:0] s);
    q14_round = (s + Q14_HALF) >>> 14;
  endfunction

endpackage

@@ hdl/nearest_point_in_box_or_sphere_top.sv @@
// nearest point in an oriented box or a sphere, fully pipelined
// depends on npbs_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis carries one query point per transaction, m_axis returns the nearest
//   point of the configured volume with the already-inside flag on tuser.
//   Configuration goes through cfg_we/cfg_index/cfg_data, one register per
//   write, while no transaction is in flight.
//   Modes: pass-through (point returned, flag set), oriented box (clamp in
//   box axes), sphere (project onto the surface when outside).
// Pipeline: COORD_WIDTH+40 register stages.
// Throughput: one point per cycle, except while the output stalls. The
//   square root takes COORD_WIDTH+1 stages, one root bit each, and the
//   scale divider 32 stages, one quotient bit each, so all three axes
//   divide side by side.
// Reset: clears all valid bits and loads the register reset values
//   (pass-through, centre at origin, identity quaternion, zero extents).
// Stall: when the output register holds a result that is not taken, the
//   whole pipeline freezes and s_axis_tready drops; nothing is lost or
//   repeated, and empty stages do not block the input.

module nearest_point_in_box_or_sphere_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // query points
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, point_z from bit 0, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // nearest points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // near_x, near_y, near_z from bit 0, zero padded to bytes
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // already_inside
  output logic        m_axis_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = npbs_pkg::RAD_W;
  localparam int MW   = npbs_pkg::MAT_W;
  localparam int QW   = npbs_pkg::QUO_W;
  localparam int SW   = CW + 1;            // offset magnitude and root width
  localparam int XW   = 2 * SW;            // squared length width
  localparam int LW   = SW + 1;            // rounded length width
  localparam int NW   = CW + 1 + RW;       // dividend width
  localparam int CMPW = (XW > 2 * RW) ? XW : 2 * RW;
  localparam int SQ0  = 5;                 // root pipeline entry
  localparam int SQN  = SQ0 + SW;          // root complete
  localparam int LS   = SQN + 1;           // length and dividend
  localparam int DN   = LS + QW;           // quotient complete
  localparam int L    = DN + 1;            // output register

  // configuration registers
  logic [1:0]           shape_mode;
  logic signed [CW-1:0] center [3];
  logic [63:0]          orientation_quat;
  logic [RW-1:0]        extent [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode       <= npbs_pkg::MODE_PASS;
      center[0]        <= '0;
      center[1]        <= '0;
      center[2]        <= '0;
      orientation_quat <= npbs_pkg::QUAT_RESET;
      extent[0]        <= '0;
      extent[1]        <= '0;
      extent[2]        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        npbs_pkg::REG_SHAPE_MODE: shape_mode       <= cfg_data[1:0];
        npbs_pkg::REG_CENTER_X:   center[0]        <= cfg_data[CW-1:0];
        npbs_pkg::REG_CENTER_Y:   center[1]        <= cfg_data[CW-1:0];
        npbs_pkg::REG_CENTER_Z:   center[2]        <= cfg_data[CW-1:0];
        npbs_pkg::REG_QUAT:       orientation_quat <= cfg_data;
        npbs_pkg::REG_EXTENT_X:   extent[0]        <= cfg_data[RW-1:0];
        npbs_pkg::REG_EXTENT_Y:   extent[1]        <= cfg_data[RW-1:0];
        npbs_pkg::REG_EXTENT_Z:   extent[2]        <= cfg_data[RW-1:0];
      endcase
    end
  end

  // saturate to the coordinate range
  function automatic logic signed [CW-1:0] sat_c(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) sat_c = hi[CW-1:0];
    else if (v < lo) sat_c = lo[CW-1:0];
    else sat_c = v[CW-1:0];
  endfunction

  // rotation matrix from the quaternion, registered
  logic signed [15:0]   qw, qx, qy, qz;
  logic signed [31:0]   xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [MW-1:0] mat_next [3][3];
  logic signed [MW-1:0] mat [3][3];
  logic [2*RW-1:0]      rr;

  always_comb begin
    qw = orientation_quat[15:0];
    qx = orientation_quat[31:16];
    qy = orientation_quat[47:32];
    qz = orientation_quat[63:48];
    xx = 32'(qx) * 32'(qx);
    yy = 32'(qy) * 32'(qy);
    zz = 32'(qz) * 32'(qz);
    xy = 32'(qx) * 32'(qy);
    xz = 32'(qx) * 32'(qz);
    yz = 32'(qy) * 32'(qz);
    wx = 32'(qw) * 32'(qx);
    wy = 32'(qw) * 32'(qy);
    wz = 32'(qw) * 32'(qz);
    mat_next[0][0] = MW'(npbs_pkg::Q14_ONE
                         - npbs_pkg::q14_round((64'(yy) + 64'(zz)) <<< 1));
    mat_next[0][1] = MW'(npbs_pkg::q14_round((64'(xy) - 64'(wz)) <<< 1));
    mat_next[0][2] = MW'(npbs_pkg::q14_round((64'(xz) + 64'(wy)) <<< 1));
    mat_next[1][0] = MW'(npbs_pkg::q14_round((64'(xy) + 64'(wz)) <<< 1));
    mat_next[1][1] = MW'(npbs_pkg::Q14_ONE
                         - npbs_pkg::q14_round((64'(xx) + 64'(zz)) <<< 1));
    mat_next[1][2] = MW'(npbs_pkg::q14_round((64'(yz) - 64'(wx)) <<< 1));
    mat_next[2][0] = MW'(npbs_pkg::q14_round((64'(xz) - 64'(wy)) <<< 1));
    mat_next[2][1] = MW'(npbs_pkg::q14_round((64'(yz) + 64'(wx)) <<< 1));
    mat_next[2][2] = MW'(npbs_pkg::Q14_ONE
                         - npbs_pkg::q14_round((64'(xx) + 64'(yy)) <<< 1));
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
    rr  <= extent[0] * extent[0];
  end

  // pipeline control: valid bits advance together
  logic       advance;
  logic [1:L] vld;

  assign advance       = !vld[L] || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {s_axis_tvalid, vld[1:L-1]};
    end
  end

  // stage registers
  logic signed [CW-1:0] pp    [1:7][3];
  logic signed [CW:0]   d2    [3];
  logic [CW:0]          ad    [2:SQN][3];
  logic                 ng    [2:L-1][3];
  logic [2*CW+1:0]      sq3   [3];
  logic signed [63:0]   prod3 [3][3];
  logic [XW-1:0]        dist4;
  logic signed [63:0]   s4    [3];
  logic signed [RW:0]   loc5  [3];
  logic [2:0]           clip5;
  logic signed [63:0]   prod6 [3][3];
  logic                 bin6, bin7;
  logic signed [63:0]   s7    [3];
  logic signed [CW-1:0] base  [8:L-1][3];
  logic                 bin   [8:L-1];
  logic                 osph  [SQ0:L-1];
  logic [XW-1:0]        sx    [SQ0:SQN-1];
  logic [SW+1:0]        srem  [SQ0:SQN];
  logic [SW-1:0]        sroot [SQ0:SQN];
  logic [LW-1:0]        dlen  [LS:DN];
  logic [LW-1:0]        drem  [LS:DN][3];
  logic [QW-1:0]        dn    [LS:DN-1][3];
  logic [QW-1:0]        dq    [LS:DN][3];
  logic signed [CW-1:0] near  [3];
  logic                 inside_q;

  // combinational helpers between stages
  logic signed [CW:0]   d1c   [3];
  logic signed [63:0]   q4c   [3];
  logic signed [63:0]   e4c   [3];
  logic [LW-1:0]        len_c;
  logic [NW-1:0]        num_c [3];
  logic                 rnd_c [3];
  logic [QW:0]          mag_c [3];
  logic signed [63:0]   sres_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1c[i] = (CW+1)'(pp[1][i]) - (CW+1)'(center[i]);
      q4c[i] = npbs_pkg::q14_round(s4[i]);
      e4c[i] = signed'(64'(extent[i]));
      num_c[i] = NW'(ad[SQN][i]) * NW'(extent[0]);
      rnd_c[i] = {drem[DN][i], 1'b0} >= {1'b0, dlen[DN]};
      if (dlen[DN] == '0) mag_c[i] = (i == 0) ? (QW+1)'(extent[0]) : '0;
      else mag_c[i] = (QW+1)'(dq[DN][i]) + (QW+1)'(rnd_c[i]);
      sres_c[i] = 64'(center[i]) + (ng[L-1][i] ? -signed'(64'(mag_c[i]))
                                               : signed'(64'(mag_c[i])));
    end
    len_c = LW'(sroot[SQN]) + LW'(srem[SQN] > (SW+2)'(sroot[SQN]));
  end

  // front stages: offset, products, sums, clamp, back-rotation
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        pp[1][i] <= s_axis_tdata[i*CW +: CW];
      end
      for (int k = 2; k <= 7; k++) pp[k] <= pp[k-1];

      // offset from the centre
      for (int i = 0; i < 3; i++) begin
        d2[i]    <= d1c[i];
        ad[2][i] <= d1c[i][CW] ? (CW+1)'(-d1c[i]) : (CW+1)'(d1c[i]);
        ng[2][i] <= d1c[i][CW];
      end
      for (int k = 3; k <= SQN; k++) ad[k] <= ad[k-1];
      for (int k = 3; k <= L-1; k++) ng[k] <= ng[k-1];

      // squares and into-box products (transpose)
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= ad[2][i] * ad[2][i];
        for (int j = 0; j < 3; j++) begin
          prod3[i][j] <= 64'(mat[j][i]) * 64'(d2[j]);
        end
      end

      // squared length and local coordinates
      dist4 <= XW'(sq3[0]) + XW'(sq3[1]) + XW'(sq3[2]);
      for (int i = 0; i < 3; i++) s4[i] <= prod3[i][0] + prod3[i][1] + prod3[i][2];

      // clamp to the half extents
      for (int i = 0; i < 3; i++) begin
        if (q4c[i] > e4c[i]) begin
          loc5[i]  <= (RW+1)'(e4c[i]);
          clip5[i] <= 1'b1;
        end else if (q4c[i] < -e4c[i]) begin
          loc5[i]  <= (RW+1)'(-e4c[i]);
          clip5[i] <= 1'b1;
        end else begin
          loc5[i]  <= (RW+1)'(q4c[i]);
          clip5[i] <= 1'b0;
        end
      end

      // rotate back
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod6[i][j] <= 64'(mat[i][j]) * 64'(loc5[j]);
      end
      bin6 <= !(|clip5);
      for (int i = 0; i < 3; i++) s7[i] <= prod6[i][0] + prod6[i][1] + prod6[i][2];
      bin7 <= bin6;

      // box or pass-through result, carried to the output
      for (int i = 0; i < 3; i++) begin
        base[8][i] <= (shape_mode == npbs_pkg::MODE_BOX)
                      ? sat_c(npbs_pkg::q14_round(s7[i]) + 64'(center[i])) : pp[7][i];
      end
      bin[8] <= (shape_mode == npbs_pkg::MODE_BOX) ? bin7 : 1'b1;
      for (int k = 9; k <= L-1; k++) begin
        base[k] <= base[k-1];
        bin[k]  <= bin[k-1];
      end

      // sphere test and root entry
      osph[SQ0] <= CMPW'(dist4) > CMPW'(rr);
      for (int k = SQ0 + 1; k <= L-1; k++) osph[k] <= osph[k-1];
      sx[SQ0]    <= dist4;
      srem[SQ0]  <= '0;
      sroot[SQ0] <= '0;

      // rounded length, dividends and divider entry
      dlen[LS] <= len_c;
      for (int i = 0; i < 3; i++) begin
        drem[LS][i] <= LW'(num_c[i] >> QW);
        dn[LS][i]   <= num_c[i][QW-1:0];
        dq[LS][i]   <= '0;
      end
    end
  end

  // square root, one root bit per stage
  for (genvar k = SQ0 + 1; k <= SQN; k++) begin : g_sqrt
    logic [SW+3:0] rt;
    logic [SW+1:0] tr;
    logic          take;

    assign rt   = {srem[k-1], sx[k-1][XW-1:XW-2]};
    assign tr   = {sroot[k-1], 2'b01};
    assign take = rt >= (SW+4)'(tr);

    always_ff @(posedge clk) begin
      if (advance) begin
        srem[k]  <= take ? (SW+2)'(rt - (SW+4)'(tr)) : rt[SW+1:0];
        sroot[k] <= {sroot[k-1][SW-2:0], take};
      end
    end

    if (k <= SQN - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (advance) sx[k] <= sx[k-1] << 2;
      end
    end
  end

  // restoring divider, one quotient bit per stage on each axis
  for (genvar k = LS + 1; k <= DN; k++) begin : g_div
    logic [LW:0] t [3];
    logic        take [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {drem[k-1][i], dn[k-1][i][QW-1]};
        take[i] = t[i] >= {1'b0, dlen[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dlen[k] <= dlen[k-1];
        for (int i = 0; i < 3; i++) begin
          drem[k][i] <= take[i] ? LW'(t[i] - {1'b0, dlen[k-1]}) : t[i][LW-1:0];
          dq[k][i]   <= {dq[k-1][i][QW-2:0], take[i]};
        end
      end
    end

    if (k <= DN - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (advance) begin
          for (int i = 0; i < 3; i++) dn[k][i] <= dn[k-1][i] << 1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        near[i] <= (shape_mode == npbs_pkg::MODE_SPHERE && osph[L-1])
                   ? sat_c(sres_c[i]) : base[L-1][i];
      end
      inside_q <= (shape_mode == npbs_pkg::MODE_SPHERE) ? !osph[L-1] : bin[L-1];
    end
  end

  always_comb begin
    m_axis_tdata           = '0;
    m_axis_tdata[3*CW-1:0] = {near[2], near[1], near[0]};
  end
  assign m_axis_tvalid = vld[L];
  assign m_axis_tuser  = inside_q;

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_pass_inside: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && shape_mode != npbs_pkg::MODE_BOX
     && shape_mode != npbs_pkg::MODE_SPHERE) |-> m_axis_tuser)
    else $error("pass-through result without inside flag");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    vld[SQN] |-> srem[SQN] <= (SW+2)'({sroot[SQN], 1'b0}))
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[DN] && dlen[DN] != '0) |-> (drem[DN][0] < dlen[DN]
      && drem[DN][1] < dlen[DN] && drem[DN][2] < dlen[DN]))
    else $error("divider remainder not below divisor");

endmodule

@@ tb/tb_nearest_point_in_box_or_sphere_top.sv @@
// self-checking testbench for nearest_point_in_box_or_sphere_top
// directed table then randomised volumes and points; depends on npbs_pkg
`timescale 1ns / 1ps

module tb_nearest_point_in_box_or_sphere_top;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 100;
  localparam logic [63:0] QUAT_DIAG = 64'h2000_2000_2000_2000;  // 120 deg about (1,1,1)

  typedef struct packed {
    logic [31:0] nz;
    logic [31:0] ny;
    logic [31:0] nx;
    logic        in_vol;
  } near_t;

  typedef struct packed {
    logic [95:0] pt;
    logic        typed;
  } query_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] cx, cy, cz;
    logic [63:0] quat;
    logic [30:0] ex, ey, ez;
  } volume_t;

  typedef struct {
    int          vol;
    logic [95:0] pt;
    logic        typed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = npbs_pkg::REG_SHAPE_MODE;
  logic [63:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic m_axis_tuser;

  // shadow of the volume registers
  volume_t vol_now;

  query_t query_backlog[$];
  near_t  nearest_due[$];
  row_t   rows[$];
  volume_t vols[6];

  logic cur_typed = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;
  int   fail_count = 0;
  int   cycles = 0;

  nearest_point_in_box_or_sphere_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounding of q14 products, ties upward
  function automatic logic signed [63:0] round_q14(input logic signed [63:0] s);
    return (s + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [63:0] widen(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // nearest point of the current volume
  function automatic near_t nearest_point(input logic [95:0] pt);
    logic signed [63:0] p[3], c[3], d[3], res[3], loc[3], e[3], m[3][3];
    logic signed [63:0] qw, qx, qy, qz, acc, mag;
    logic [63:0] ad[3], len;
    logic [127:0] dist_sq, rr, root, t, n, q, rem;
    near_t r;
    r.in_vol = 1'b1;
    for (int i = 0; i < 3; i++) p[i] = widen(pt[32*i +: 32]);
    c[0] = widen(vol_now.cx);
    c[1] = widen(vol_now.cy);
    c[2] = widen(vol_now.cz);
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - c[i];
      res[i] = p[i];
    end
    case (vol_now.mode)
      npbs_pkg::MODE_BOX: begin
        qw = {{48{vol_now.quat[15]}}, vol_now.quat[15:0]};
        qx = {{48{vol_now.quat[31]}}, vol_now.quat[31:16]};
        qy = {{48{vol_now.quat[47]}}, vol_now.quat[47:32]};
        qz = {{48{vol_now.quat[63]}}, vol_now.quat[63:48]};
        m[0][0] = 64'sd16384 - round_q14(2 * (qy * qy + qz * qz));
        m[0][1] = round_q14(2 * (qx * qy - qw * qz));
        m[0][2] = round_q14(2 * (qx * qz + qw * qy));
        m[1][0] = round_q14(2 * (qx * qy + qw * qz));
        m[1][1] = 64'sd16384 - round_q14(2 * (qx * qx + qz * qz));
        m[1][2] = round_q14(2 * (qy * qz - qw * qx));
        m[2][0] = round_q14(2 * (qx * qz - qw * qy));
        m[2][1] = round_q14(2 * (qy * qz + qw * qx));
        m[2][2] = 64'sd16384 - round_q14(2 * (qx * qx + qy * qy));
        e[0] = {33'd0, vol_now.ex};
        e[1] = {33'd0, vol_now.ey};
        e[2] = {33'd0, vol_now.ez};
        // into box axes by the transpose, clamp each axis
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc = acc + m[j][i] * d[j];
          loc[i] = round_q14(acc);
          if (loc[i] > e[i]) begin
            loc[i] = e[i];
            r.in_vol = 1'b0;
          end else if (loc[i] < -e[i]) begin
            loc[i] = -e[i];
            r.in_vol = 1'b0;
          end
        end
        // back to world axes
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc = acc + m[i][j] * loc[j];
          res[i] = round_q14(acc) + c[i];
        end
      end
      npbs_pkg::MODE_SPHERE: begin
        dist_sq = '0;
        for (int i = 0; i < 3; i++) begin
          ad[i] = (d[i] < 0) ? -d[i] : d[i];
          dist_sq = dist_sq + {64'd0, ad[i]} * {64'd0, ad[i]};
        end
        rr = {97'd0, vol_now.ex} * {97'd0, vol_now.ex};
        if (dist_sq > rr) begin
          r.in_vol = 1'b0;
          root = '0;
          for (int b = 63; b >= 0; b--) begin
            t = root | (128'd1 << b);
            if (t * t <= dist_sq) root = t;
          end
          if (dist_sq > root * root + root) root = root + 1;
          len = root[63:0];
          for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
              mag = (i == 0) ? {33'd0, vol_now.ex} : 64'sd0;
            end else begin
              n = {64'd0, ad[i]} * {97'd0, vol_now.ex};
              q = n / len;
              rem = n - q * len;
              if (rem >= len - rem) q = q + 1;
              mag = q[63:0];
            end
            res[i] = c[i] + ((d[i] < 0) ? -mag : mag);
          end
        end
      end
      default: ;
    endcase
    r.nx = clip32(res[0]);
    r.ny = clip32(res[1]);
    r.nz = clip32(res[2]);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender: queued transactions with random gaps between them, sometimes none
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        nearest_due.push_back(cur_typed ? near_t'({s_axis_tdata, 1'b1})
                                        : nearest_point(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (query_backlog.size() > 0) begin
          query_t qi;
          qi = query_backlog.pop_front();
          s_axis_tdata <= qi.pt;
          cur_typed <= qi.typed;
          s_axis_tvalid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      near_t got, want;
      got = {m_axis_tdata, m_axis_tuser};
      if (nearest_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = nearest_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected x=%h y=%h z=%h in=%b, got x=%h y=%h z=%h in=%b",
                     want.nx, want.ny, want.nz, want.in_vol,
                     got.nx, got.ny, got.nz, got.in_vol);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (query_backlog.size() > 0 || s_axis_tvalid || nearest_due.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // write every register of a volume, then drop the enable
  task automatic apply_volume(input volume_t v);
    logic [63:0] vals[8];
    vals[0] = {62'd0, v.mode};
    vals[1] = {32'd0, v.cx};
    vals[2] = {32'd0, v.cy};
    vals[3] = {32'd0, v.cz};
    vals[4] = v.quat;
    vals[5] = {33'd0, v.ex};
    vals[6] = {33'd0, v.ey};
    vals[7] = {33'd0, v.ez};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    vol_now = v;
  endtask

  task automatic add_row(input int vol, input logic [31:0] x, y, z, input logic typed);
    row_t r;
    r.vol = vol;
    r.pt = {z, y, x};
    r.typed = typed;
    rows.push_back(r);
  endtask

  function automatic logic [31:0] near_coord(input logic [31:0] centre);
    logic [31:0] off;
    if ($urandom_range(0, 7) == 0) return $urandom;
    off = $urandom & ((32'd1 << $urandom_range(2, 26)) - 1);
    return $urandom_range(0, 1) ? centre + off : centre - off;
  endfunction

  function automatic logic [30:0] rand_extent();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  function automatic logic [63:0] rand_quat();
    case ($urandom_range(0, 6))
      0: return npbs_pkg::QUAT_RESET;
      1: return 64'h0000_0000_2D41_2D41;   // 90 deg about x
      2: return 64'h4000_0000_0000_0000;   // 180 deg about z
      3: return QUAT_DIAG;
      4: return 64'h0000_187E_0000_3B21;   // 45 deg about y
      5: return {$urandom, $urandom};
      default: return 64'hC000_0000_0000_0000;
    endcase
  endfunction

  initial begin
    volume_t v;
    int cur;
    vol_now = '{npbs_pkg::MODE_PASS, 32'd0, 32'd0, 32'd0, npbs_pkg::QUAT_RESET,
                31'd0, 31'd0, 31'd0};
    vols[0] = vol_now;
    vols[1] = '{npbs_pkg::MODE_BOX, 32'h0003_E800, 32'hFFF8_3000, 32'h0000_12C0,
                npbs_pkg::QUAT_RESET, 31'd25600, 31'd12800, 31'd0};
    vols[2] = '{npbs_pkg::MODE_BOX, 32'd0, 32'd0, 32'd0, QUAT_DIAG,
                31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    vols[3] = '{npbs_pkg::MODE_SPHERE, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FD00,
                npbs_pkg::QUAT_RESET, 31'd5120, 31'd0, 31'd0};
    vols[4] = '{npbs_pkg::MODE_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                npbs_pkg::QUAT_RESET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    vols[5] = '{MODE_UNDEF, 32'h1234_5678, 32'h8765_4321, 32'd0, {$urandom, $urandom},
                31'd99, 31'd99, 31'd99};

    // pass-through after reset: point comes straight back
    add_row(0, 32'h0, 32'h0, 32'h0, 1);
    add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1);
    add_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1);
    add_row(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1);
    // axis-aligned box: inside, on faces, outside, flat z
    add_row(1, 32'h0003_E800, 32'hFFF8_3000, 32'h0000_12C0, 0);
    add_row(1, 32'h0004_4C00, 32'hFFF8_6200, 32'h0000_12C0, 0);
    add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_row(1, 32'h0003_E900, 32'hFFF8_3000, 32'h0000_12C1, 0);
    // rotated box with extreme extents, saturating corners
    add_row(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    add_row(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_row(2, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0000, 0);
    // sphere: centre itself, inside, on surface, outside along x, along y and diagonally
    add_row(3, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FD00, 0);
    add_row(3, 32'h0000_0200, 32'h0000_0200, 32'hFFFF_FD00, 0);
    add_row(3, 32'h0000_1500, 32'h0000_0200, 32'hFFFF_FD00, 0);
    add_row(3, 32'h0000_1501, 32'h0000_0200, 32'hFFFF_FD00, 0);
    add_row(3, 32'h0000_0100, 32'h8000_0000, 32'hFFFF_FD00, 0);
    add_row(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    // huge sphere, extreme centre, saturation
    add_row(4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_row(4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    add_row(4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    // undefined mode behaves as pass-through
    add_row(5, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1);
    add_row(5, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0000_0000, 1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].vol != cur) begin
        wait_idle();
        cur = rows[i].vol;
        apply_volume(vols[cur]);
      end
      query_backlog.push_back('{rows[i].pt, rows[i].typed});
    end

    // random volumes, points mostly around the centre
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: v.mode = npbs_pkg::MODE_PASS;
        1: v.mode = MODE_UNDEF;
        2, 3, 4, 5: v.mode = npbs_pkg::MODE_BOX;
        default: v.mode = npbs_pkg::MODE_SPHERE;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        v.cx = $urandom;
        v.cy = $urandom;
        v.cz = $urandom;
      end else begin
        v.cx = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        v.cy = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        v.cz = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      v.quat = rand_quat();
      v.ex = rand_extent();
      v.ey = rand_extent();
      v.ez = rand_extent();
      apply_volume(v);
      calm = (ph % 4 == 1);
      for (int k = 0; k < 85; k++)
        query_backlog.push_back('{{near_coord(v.cz), near_coord(v.cy), near_coord(v.cx)},
                                  1'b0});
    end

    while (query_backlog.size() > 0 || s_axis_tvalid || nearest_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
